// ===== rtl/gse_pkg.sv =====
// shared types, constants and helper functions of the gaussian/sobel edge detector
package gse_pkg;

	localparam int PIX_W         = 8;
	localparam int COL_W         = 11;
	localparam int ROW_W         = 13;
	localparam int THR_W         = 11;
	localparam int GRAD_W        = 11;
	localparam int MAG_W         = 2 * THR_W;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_SIZE      = 3;
	localparam int WIN_N         = 9;
	localparam int WIN_CENTER    = 4;

	localparam logic [COL_W-1:0] WIDTH_RST  = COL_W'(640);
	localparam logic [ROW_W-1:0] HEIGHT_RST = ROW_W'(480);
	localparam logic [THR_W-1:0] THRESH_RST = THR_W'(150);

	localparam logic [PIX_W-1:0] PIX_EDGE = PIX_W'(0);
	localparam logic [PIX_W-1:0] PIX_FLAT = PIX_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2
	} cfg_reg_t;

	typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

	// per-item control, worked out when the item enters
	typedef struct packed {
		logic [PIX_W-1:0] x;          // raw pixel, zero in the tail
		logic [COL_W-1:0] col;        // raw line column
		logic             smooth_en;  // item emits a smoothed pixel
		logic [COL_W-1:0] qc;         // column of that smoothed pixel
		logic             border;     // smoothed pixel sits on the frame border
		logic             produce;    // item emits a result
		logic             sb;         // result sits on the frame border
		logic             last;       // result closes the frame
	} item_t;

	function automatic logic [COL_W-1:0] clamp_width(input logic [COL_W-1:0] v, input int hi);
		if (v < COL_W'(MIN_SIZE)) return COL_W'(MIN_SIZE);
		if (int'(v) > hi) return COL_W'(hi);
		return v;
	endfunction

	function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] v);
		if (v < ROW_W'(MIN_SIZE)) return ROW_W'(MIN_SIZE);
		if (v > ROW_W'(MAX_HEIGHT)) return ROW_W'(MAX_HEIGHT);
		return v;
	endfunction

	// shift a window one column left and put the new column on the right
	function automatic win_t push_col(input win_t w, input logic [PIX_W-1:0] older,
			input logic [PIX_W-1:0] newer, input logic [PIX_W-1:0] value);
		win_t n;
		for (int r = 0; r < 3; r++) begin
			n[r*3]   = w[r*3+1];
			n[r*3+1] = w[r*3+2];
		end
		n[2] = older;
		n[5] = newer;
		n[8] = value;
		return n;
	endfunction

	// 1 2 1 / 2 4 2 / 1 2 1, divided by 16
	function automatic logic [PIX_W-1:0] smooth_of(input win_t w);
		logic [PIX_W+3:0] s;
		s = (PIX_W+4)'(w[0]) + ((PIX_W+4)'(w[1]) << 1) + (PIX_W+4)'(w[2])
		  + ((PIX_W+4)'(w[3]) << 1) + ((PIX_W+4)'(w[4]) << 2) + ((PIX_W+4)'(w[5]) << 1)
		  + (PIX_W+4)'(w[6]) + ((PIX_W+4)'(w[7]) << 1) + (PIX_W+4)'(w[8]);
		return s[PIX_W+3:4];
	endfunction

	// weighted difference of two pixel triples: (a + 2b + c) - (d + 2e + f)
	function automatic logic signed [GRAD_W-1:0] tri_diff(
			input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
			input logic [PIX_W-1:0] d, input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] f);
		logic [GRAD_W-2:0] p;
		logic [GRAD_W-2:0] n;
		p = (GRAD_W-1)'(a) + ((GRAD_W-1)'(b) << 1) + (GRAD_W-1)'(c);
		n = (GRAD_W-1)'(d) + ((GRAD_W-1)'(e) << 1) + (GRAD_W-1)'(f);
		return $signed({1'b0, p}) - $signed({1'b0, n});
	endfunction

endpackage

// ===== rtl/gse_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
module gse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/gse_ctrl.sv =====
// configuration registers, frame position counters and per-item control
module gse_ctrl #(
	parameter int MAX_WIDTH = gse_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [gse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gse_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	input  logic                            advance,
	input  logic [gse_pkg::PIX_W-1:0]       pixel,
	input  logic                            drain,
	output logic                            item_valid,
	output gse_pkg::item_t                  item,
	output logic [gse_pkg::MAG_W-1:0]       thr_sq
);
	import gse_pkg::*;

	localparam logic [MAG_W-1:0] THR_SQ_RST = MAG_W'(THRESH_RST) * MAG_W'(THRESH_RST);

	logic [COL_W-1:0] w_q;
	logic [ROW_W-1:0] h_q;
	logic [THR_W-1:0] thr_q;
	logic [MAG_W-1:0] thr_sq_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic             in_frame;
	logic             size_wr;
	logic [ROW_W-1:0] qr;
	logic [COL_W-1:0] qc;

	assign size_wr = cfg_wen && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	always_comb begin
		in_frame   = in_row_q < h_q;
		// a drain before the frame's last pixel is dropped here
		item_valid = in_valid && advance && !(in_frame && drain);
		if (in_col_q != '0) begin
			qr = in_row_q - ROW_W'(1);
			qc = in_col_q - COL_W'(1);
		end else begin
			qr = in_row_q - ROW_W'(2);
			qc = w_q - COL_W'(1);
		end
		item.x         = in_frame ? pixel : '0;
		item.col       = in_col_q;
		item.smooth_en = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
		item.qc        = qc;
		item.border    = qr == '0 || qr >= h_q - ROW_W'(1) || qc == '0 || qc >= w_q - COL_W'(1);
		item.produce   = (in_row_q >= ROW_W'(3)) || (in_row_q == ROW_W'(2) && in_col_q >= COL_W'(2));
		item.sb        = out_row_q == '0 || out_row_q >= h_q - ROW_W'(1)
		              || out_col_q == '0 || out_col_q >= w_q - COL_W'(1);
		item.last      = out_row_q == h_q - ROW_W'(1) && out_col_q == w_q - COL_W'(1);
	end

	assign thr_sq = thr_sq_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= clamp_width(WIDTH_RST, MAX_WIDTH);
			h_q      <= clamp_height(HEIGHT_RST);
			thr_q    <= THRESH_RST;
			thr_sq_q <= THR_SQ_RST;
		end else begin
			thr_sq_q <= MAG_W'(thr_q) * MAG_W'(thr_q);
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_WIDTH:  w_q   <= clamp_width(cfg_wdata[COL_W-1:0], MAX_WIDTH);
					REG_HEIGHT: h_q   <= clamp_height(cfg_wdata[ROW_W-1:0]);
					REG_THRESH: thr_q <= cfg_wdata[THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			priority if (size_wr || (item_valid && item.produce && item.last)) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (item_valid) begin
				if (item.produce) begin
					if (out_col_q == w_q - COL_W'(1)) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
				if (in_col_q == w_q - COL_W'(1)) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end else begin
				// no request this cycle, position holds
			end
		end
	end

	a_size_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		size_wr |=> in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0)
		else $error("size write did not restart the frame");

	a_out_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_col_q < w_q && in_col_q < w_q)
		else $error("column counter beyond image width");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item.produce && item.last |=> in_row_q == '0 && out_row_q == '0)
		else $error("frame end did not restart the counters");

endmodule

// ===== rtl/gse_gauss.sv =====
// raw line memory, raw window and gaussian smoothing
module gse_gauss #(
	parameter int MAX_WIDTH = gse_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic                      in_valid,
	input  gse_pkg::item_t            item,
	output logic                      valid_s2,
	output gse_pkg::item_t            item_s2,
	output logic [gse_pkg::PIX_W-1:0] sv_s2
);
	import gse_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic               valid_s1;
	item_t              item_s1;
	logic [2*PIX_W-1:0] rd_s1;     // {older row, newer row}
	win_t               win_q;

	gse_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_raw_line (
		.clk   (clk),
		.wen   (valid_s1 && advance),
		.waddr (AW'(item_s1.col)),
		.wdata ({rd_s1[PIX_W-1:0], item_s1.x}),
		.ren   (advance),
		.raddr (AW'(item.col)),
		.rdata (rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			win_q    <= '0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				win_q <= push_col(win_q, rd_s1[2*PIX_W-1:PIX_W], rd_s1[PIX_W-1:0], item_s1.x);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item;
			item_s2 <= item_s1;
		end
	end

	assign sv_s2 = item_s2.border ? win_q[WIN_CENTER] : smooth_of(win_q);

endmodule

// ===== rtl/gse_sobel.sv =====
// smoothed line memory, smoothed window, sobel gradients and threshold
module gse_sobel #(
	parameter int MAX_WIDTH = gse_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic                      valid_s2,
	input  gse_pkg::item_t            item_s2,
	input  logic [gse_pkg::PIX_W-1:0] sv_s2,
	input  logic [gse_pkg::MAG_W-1:0] thr_sq,
	output logic                      res_valid,
	output logic [gse_pkg::PIX_W-1:0] res_pixel,
	output logic                      res_last
);
	import gse_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic                     valid_s3;
	logic                     valid_s4;
	logic                     valid_s5;
	item_t                    item_s3;
	item_t                    item_s4;
	item_t                    item_s5;
	logic [PIX_W-1:0]         sv_s3;
	logic [2*PIX_W-1:0]       rd_s3;     // {older row, newer row}
	win_t                     swin_q;
	logic signed [GRAD_W-1:0] v_s5;
	logic signed [GRAD_W-1:0] h_s5;
	logic [PIX_W-1:0]         center_s5;
	logic signed [2*GRAD_W-1:0] vv;
	logic signed [2*GRAD_W-1:0] hh;
	logic [MAG_W:0]           mag;
	logic                     push_s3;

	assign push_s3 = valid_s3 && item_s3.smooth_en;

	gse_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_smooth_line (
		.clk   (clk),
		.wen   (push_s3 && advance),
		.waddr (AW'(item_s3.qc)),
		.wdata ({rd_s3[PIX_W-1:0], sv_s3}),
		.ren   (advance),
		.raddr (AW'(item_s2.qc)),
		.rdata (rd_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			swin_q   <= '0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			if (push_s3) begin
				swin_q <= push_col(swin_q, rd_s3[2*PIX_W-1:PIX_W], rd_s3[PIX_W-1:0], sv_s3);
			end
		end
	end

	// gradients from the window as it stands after this item's column
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s3   <= item_s2;
			sv_s3     <= sv_s2;
			item_s4   <= item_s3;
			item_s5   <= item_s4;
			v_s5      <= tri_diff(swin_q[6], swin_q[7], swin_q[8], swin_q[0], swin_q[1], swin_q[2]);
			h_s5      <= tri_diff(swin_q[2], swin_q[5], swin_q[8], swin_q[0], swin_q[3], swin_q[6]);
			center_s5 <= swin_q[WIN_CENTER];
		end
	end

	always_comb begin
		vv  = v_s5 * v_s5;
		hh  = h_s5 * h_s5;
		mag = (MAG_W+1)'(unsigned'(vv)) + (MAG_W+1)'(unsigned'(hh));
	end

	assign res_valid = valid_s5 && item_s5.produce;
	assign res_last  = item_s5.last;
	assign res_pixel = item_s5.sb ? center_s5
	                 : ((mag >= (MAG_W+1)'(thr_sq)) ? PIX_EDGE : PIX_FLAT);

endmodule

// ===== rtl/gaussian_sobel_edge_detector_core.sv =====
// top level of the streaming 3x3 gaussian smoothing and sobel edge detector
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: pixel, tuser: drain
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: edge_pixel, tlast: frame_last
//  cfg       in         cfg_wen (no wait)              cfg_index, cfg_wdata
//
//  one request per clock while m_axis_tready does not hold the pipeline; a request passes
//  five pipeline stages and then the output register before its result shows
//  each result belongs to the pixel two rows plus two pixels back; the frame tail is
//  pushed out by 2*width+2 drain requests after the last pixel
//  the raw and smoothed line memories are read one stage and written back the next;
//  a column is revisited only width (at least three) requests later, so no forwarding
//  reset clears counters, windows and valid bits; line memories are not cleared and
//  there is no clearing pass
//  m_axis_tready low with a result waiting freezes every stage and s_axis_tready
module gaussian_sobel_edge_detector_core #(
	parameter int MAX_WIDTH = gse_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input pixel stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel
	input  logic                           s_axis_tuser,   // [0] drain
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,   // [7:0] edge_pixel
	output logic                           m_axis_tlast,   // frame_last
	// configuration writes
	input  logic                           cfg_wen,
	input  logic [gse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gse_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import gse_pkg::*;

	logic             advance;
	logic             item_valid;
	item_t            item;
	logic [MAG_W-1:0] thr_sq;
	logic             valid_s2;
	item_t            item_s2;
	logic [PIX_W-1:0] sv_s2;
	logic             res_valid;
	logic [PIX_W-1:0] res_pixel;
	logic             res_last;

	logic             m_valid_q;
	logic [PIX_W-1:0] m_data_q;
	logic             m_last_q;

	// whole pipeline moves whenever the output register can take a new value
	assign advance       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = advance;

	// stage 0: counters and per-request control
	gse_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.advance    (advance),
		.pixel      (s_axis_tdata),
		.drain      (s_axis_tuser),
		.item_valid (item_valid),
		.item       (item),
		.thr_sq     (thr_sq)
	);

	// stages 1-2: raw line memory and smoothing
	gse_gauss #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_gauss (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (item_valid),
		.item     (item),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.sv_s2    (sv_s2)
	);

	// stages 3-5: smoothed line memory, gradients, threshold
	gse_sobel #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_sobel (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.valid_s2  (valid_s2),
		.item_s2   (item_s2),
		.sv_s2     (sv_s2),
		.thr_sq    (thr_sq),
		.res_valid (res_valid),
		.res_pixel (res_pixel),
		.res_last  (res_last)
	);

	// output register, parts the pipeline from the downstream side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			m_data_q <= res_pixel;
			m_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

// ===== tb/gse_edge_checker.sv =====
// result predictor and output stream checker for the gaussian/sobel edge detector
module gse_edge_checker #(
	parameter int MAX_W = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     in_pixel,
	input  logic                           in_drain,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [7:0]                     out_pixel,
	input  logic                           out_last,
	input  logic                           cfg_wen,
	input  logic [gse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gse_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             fail_count,
	output int                             outstanding,
	output int                             results_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import gse_pkg::*;

	localparam int RAW      = 0;
	localparam int SMOOTHED = 1;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} result_t;

	logic [COL_W-1:0] width_reg;
	logic [ROW_W-1:0] height_reg;
	logic [THR_W-1:0] thresh_reg;

	// two 3x3 windows and two line memories, one pair per filter stage
	logic [PIX_W-1:0] window [2][WIN_N];
	logic [PIX_W-1:0] line_mem [2][2*MAX_W];

	int in_col, in_row, out_col, out_row;
	result_t pending_results [$];
	result_t oldest;

	function automatic void restart_frame();
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// new column: two stored rows on top, the incoming value at the bottom
	function automatic void shift_column(int stg, int col, logic [PIX_W-1:0] val);
		int c;
		int k;
		logic [PIX_W-1:0] older;
		logic [PIX_W-1:0] newer;
		c = col % MAX_W;
		older = line_mem[stg][MAX_W + c];
		newer = line_mem[stg][c];
		line_mem[stg][MAX_W + c] = newer;
		line_mem[stg][c] = val;
		for (k = 0; k < 3; k++) begin
			window[stg][k*3]   = window[stg][k*3+1];
			window[stg][k*3+1] = window[stg][k*3+2];
		end
		window[stg][2] = older;
		window[stg][5] = newer;
		window[stg][8] = val;
	endfunction

	function automatic int px(int stg, int k);
		return int'(window[stg][k]);
	endfunction

	function automatic logic [PIX_W-1:0] smoothed_center();
		int s;
		s = px(RAW, 0) + 2*px(RAW, 1) + px(RAW, 2)
		  + 2*px(RAW, 3) + 4*px(RAW, 4) + 2*px(RAW, 5)
		  + px(RAW, 6) + 2*px(RAW, 7) + px(RAW, 8);
		return PIX_W'(s >> 4);
	endfunction

	// squared magnitude against squared threshold
	function automatic logic [PIX_W-1:0] sobel_verdict();
		int v;
		int h;
		int t;
		v = (px(SMOOTHED, 6) + 2*px(SMOOTHED, 7) + px(SMOOTHED, 8))
		  - (px(SMOOTHED, 0) + 2*px(SMOOTHED, 1) + px(SMOOTHED, 2));
		h = (px(SMOOTHED, 2) + 2*px(SMOOTHED, 5) + px(SMOOTHED, 8))
		  - (px(SMOOTHED, 0) + 2*px(SMOOTHED, 3) + px(SMOOTHED, 6));
		t = int'(thresh_reg);
		return (v*v + h*h >= t*t) ? PIX_EDGE : PIX_FLAT;
	endfunction

	function automatic void predict_request(logic [PIX_W-1:0] pix, logic drain);
		int w;
		int h;
		int qr;
		int qc;
		logic in_frame;
		logic border;
		logic sb;
		logic last;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] sv;
		result_t r;
		w = int'(width_reg);
		if (w < MIN_SIZE) w = MIN_SIZE;
		if (w > MAX_W) w = MAX_W;
		h = int'(height_reg);
		if (h < MIN_SIZE) h = MIN_SIZE;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;

		in_frame = in_row < h;
		if (in_frame && drain) return;
		x = in_frame ? pix : '0;
		shift_column(RAW, in_col, x);

		if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
			if (in_col >= 1) begin
				qr = in_row - 1;
				qc = in_col - 1;
			end else begin
				qr = in_row - 2;
				qc = w - 1;
			end
			border = qr == 0 || qr >= h - 1 || qc == 0 || qc >= w - 1;
			sv = border ? window[RAW][WIN_CENTER] : smoothed_center();
			shift_column(SMOOTHED, qc, sv);

			if (in_row >= 3 || (in_row == 2 && in_col >= 2)) begin
				sb = out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1;
				last = out_row == h - 1 && out_col == w - 1;
				r.pix = sb ? window[SMOOTHED][WIN_CENTER] : sobel_verdict();
				r.last = last;
				pending_results.push_back(r);
				if (last) begin
					restart_frame();
					return;
				end
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
		end

		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			thresh_reg = THRESH_RST;
			for (int s = 0; s < 2; s++) begin
				for (int k = 0; k < WIN_N; k++) window[s][k] = '0;
				for (int k = 0; k < 2*MAX_W; k++) line_mem[s][k] = '0;
			end
			restart_frame();
			pending_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_WIDTH: begin
						width_reg = cfg_wdata[COL_W-1:0];
						restart_frame();
					end
					REG_HEIGHT: begin
						height_reg = cfg_wdata[ROW_W-1:0];
						restart_frame();
					end
					REG_THRESH: thresh_reg = cfg_wdata[THR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_request(in_pixel, in_drain);
			if (out_valid && out_ready) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					note_failure($sformatf("unexpected result pixel %0d last %0b",
						out_pixel, out_last));
				end else begin
					oldest = pending_results.pop_front();
					if (out_pixel !== oldest.pix || out_last !== oldest.last)
						note_failure($sformatf(
							"result %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
							results_checked, oldest.pix, oldest.last, out_pixel, out_last));
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== tb/tb_gaussian_sobel_edge_detector_core.sv =====
// stimulus and verdict for the streaming gaussian/sobel edge detector core
module tb_gaussian_sobel_edge_detector_core;
	timeunit 1ns;
	timeprecision 1ps;
	import gse_pkg::*;

	localparam int FRAME_MAX_W = MAX_WIDTH_DEF;
	// receiver hold-off that backs the pipeline up into the input
	localparam int HOLD_CYCLES = 400;
	// cycles allowed after the last expected result for in-flight requests
	localparam int SETTLE_CYCLES = 12;
	// pixels sent into each of the two largest frames before they are dropped
	localparam int LARGE_PART = 160;
	// index past the end of the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum int {
		PAT_NOISE,
		PAT_FLAT,
		PAT_STEP,
		PAT_RAMP,
		PAT_EXTREME
	} pattern_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;   // [7:0] pixel
	logic                  s_axis_tuser;   // [0] drain
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;   // [7:0] edge_pixel
	logic                  m_axis_tlast;   // frame_last
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int outstanding;
	int results_checked;

	// traffic shaping; idle_pct is shared by the sender and the receiver, hold_req is the receiver's alone
	int   idle_pct;
	logic hold_req;

	// effective frame size as the block sees it after clamping
	int cur_w;
	int cur_h;
	int items_sent;
	int frames_done;

	gaussian_sobel_edge_detector_core #(
		.MAX_WIDTH(FRAME_MAX_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// watches all three channels, predicts every result and counts mismatches
	gse_edge_checker #(
		.MAX_W(FRAME_MAX_W)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_pixel        (s_axis_tdata),
		.in_drain        (s_axis_tuser),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_pixel       (m_axis_tdata),
		.out_last        (m_axis_tlast),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#30_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request;
	// every branch drives tready once at its first falling edge
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic int clamp_dim(int v, int hi);
		if (v < MIN_SIZE) return MIN_SIZE;
		if (v > hi) return hi;
		return v;
	endfunction

	// image content: noise and extreme give strong gradients, flat/ramp/step give weak or local ones
	function automatic logic [7:0] make_pixel(pattern_t pat, int r, int c, int w,
			logic [7:0] a, logic [7:0] b);
		case (pat)
			PAT_NOISE:   return 8'($urandom_range(0, 255));
			PAT_FLAT:    return a;
			PAT_STEP:    return (c * 2 < w) ? a : b;
			PAT_RAMP:    return 8'(int'(a) + (r + c) * int'(b[2:0]));
			PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:     return a;
		endcase
	endfunction

	// one request on the input stream; returns right after the accepting edge
	task automatic push_request(logic [7:0] pix, logic drn);
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= drn;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic idle_input();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// wait until every predicted result has come out, then let the pipe empty
	task automatic settle();
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// all registers are written with the block idle; a size write also drops
	// any partial frame, which is how abandoned frames get covered
	task automatic reconfigure(int wd, int hd, int td);
		idle_input();
		settle();
		if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_write(REG_WIDTH, CFG_DATA_W'(wd));
		cfg_write(REG_HEIGHT, CFG_DATA_W'(hd));
		cfg_write(REG_THRESH, CFG_DATA_W'(td));
		cur_w = clamp_dim(wd & 'h7FF, FRAME_MAX_W);
		cur_h = clamp_dim(hd & 'h1FFF, MAX_HEIGHT);
	endtask

	// a frame of stop_at pixels; a full frame is followed by its 2w+2 tail
	// requests. retune_at >= 0 rewrites the threshold mid-frame with the pipe idle
	task automatic run_frame(pattern_t pat, int stop_at, int retune_at);
		int n;
		logic [7:0] a;
		logic [7:0] b;
		a = 8'($urandom);
		b = 8'($urandom);
		for (n = 0; n < stop_at; n++) begin
			if (n == retune_at) begin
				idle_input();
				settle();
				cfg_write(REG_THRESH, CFG_DATA_W'($urandom_range(0, 1500)));
			end
			// drain inside the frame: must be ignored
			if ($urandom_range(0, 99) < 4) push_request(8'($urandom), 1'b1);
			push_request(make_pixel(pat, n / cur_w, n % cur_w, cur_w, a, b), 1'b0);
			items_sent++;
		end
		if (stop_at == cur_w * cur_h) begin
			// tail: plain pixels here act as drains, their value is dropped
			for (n = 0; n < 2 * cur_w + 2; n++) begin
				push_request(8'($urandom), ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1);
				items_sent++;
			end
			frames_done++;
		end
	endtask

	// stimulus
	initial begin
		logic [7:0] corner_img [9];
		int n;
		int rand_goal;
		int wd;
		int hd;
		int td;
		int stop;
		int retune;
		int wait_cycles;
		logic first_random;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = REG_WIDTH;
		cfg_wdata     = '0;
		idle_pct      = 0;
		hold_req      = 1'b0;
		items_sent    = 0;
		frames_done   = 0;
		cur_w         = 640;
		cur_h         = 480;
		corner_img    = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset size, a few pixels that cannot produce a result yet
		for (n = 0; n < 5; n++) push_request(8'(n * 63), 1'b0);
		push_request(8'hAA, 1'b1);
		// smallest frame, vertical step at column one, drain in mid-frame,
		// tail mixing drains and discarded pixels
		reconfigure(3, 3, 150);
		for (n = 0; n < 9; n++) begin
			push_request(corner_img[n], 1'b0);
			if (n == 4) push_request(8'h5A, 1'b1);
		end
		for (n = 0; n < 8; n++) push_request(8'hFF, n[0]);
		items_sent += 17;
		frames_done++;

		// threshold extremes and clamped-up sizes
		idle_pct = 20;
		reconfigure(4, 4, 0);
		run_frame(PAT_NOISE, cur_w * cur_h, -1);
		reconfigure(5, 3, 1500);
		run_frame(PAT_EXTREME, cur_w * cur_h, -1);
		run_frame(PAT_STEP, cur_w * cur_h, -1);
		reconfigure(0, 1, 2047);
		run_frame(PAT_EXTREME, cur_w * cur_h, -1);
		reconfigure(2, 2, 1);
		run_frame(PAT_RAMP, cur_w * cur_h, 4);

		// random frames; the first one runs under a long output hold-off
		rand_goal = items_sent + 760;
		first_random = 1'b1;
		while (items_sent < rand_goal) begin
			wd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			// upper data bits lie outside the width register and are dropped
			if ($urandom_range(0, 5) == 0) wd = wd | 'h1800;
			hd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			case ($urandom_range(0, 5))
				0:       td = 0;
				1:       td = 1500;
				2:       td = 2047;
				3:       td = $urandom_range(0, 1500);
				default: td = $urandom_range(0, 400);
			endcase
			idle_pct = $urandom_range(0, 2) * 15;
			reconfigure(wd, hd, td);
			stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cur_w * cur_h - 1)
				: cur_w * cur_h;
			retune = ($urandom_range(0, 7) == 0) ? $urandom_range(0, stop - 1) : -1;
			if (first_random) begin
				hold_req = 1'b1;
				first_random = 1'b0;
			end
			run_frame(pattern_t'($urandom_range(0, 4)), stop, retune);
			// back-to-back frame with no register write in between
			if (stop == cur_w * cur_h && $urandom_range(0, 1) == 0)
				run_frame(pattern_t'($urandom_range(0, 4)), cur_w * cur_h, -1);
		end

		// largest sizes, both reached through clamping from the register maximum;
		// only the opening pixels of each are sent, the next size write drops the rest
		idle_pct = 5;
		reconfigure(2047, 3, $urandom_range(0, 1500));
		run_frame(PAT_NOISE, LARGE_PART, -1);
		reconfigure(3, 8191, $urandom_range(0, 400));
		run_frame(PAT_STEP, LARGE_PART, -1);

		// closing stretch with both sides always ready
		idle_pct = 0;
		reconfigure(9, 6, 60);
		run_frame(PAT_RAMP, cur_w * cur_h, -1);
		run_frame(PAT_NOISE, cur_w * cur_h, -1);

		idle_input();
		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (20) @(negedge clk);

		$display("%0d requests sent, %0d full frames, %0d results compared",
			items_sent, frames_done, results_checked);
		$display("full frames 3x3 to 12x8, opening rows at %0d wide and %0d high, %s%0d",
			FRAME_MAX_W, MAX_HEIGHT, "thresholds 0 to 2047, one hold of cycles ", HOLD_CYCLES);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			if (outstanding != 0) $display("%0d predicted results never arrived", outstanding);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/gse_pkg.sv
rtl/gse_ram.sv
rtl/gse_ctrl.sv
rtl/gse_gauss.sv
rtl/gse_sobel.sv
rtl/gaussian_sobel_edge_detector_core.sv
tb/gse_edge_checker.sv
tb/tb_gaussian_sobel_edge_detector_core.sv
